@@ sv/hslw_pkg.sv @@
// Shared types and constants for the HSL color wheel pixel pipeline.
// Holds the CORDIC arctangent table, the CORDIC gain constant and the control struct.
// No dependencies.
package hslw_pkg;

    // Number of CORDIC micro-rotations, one pipeline stage each
    localparam int CORDIC_STEPS = 16;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C
    };

    // 1/K of the CORDIC gain in Q32
    localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

    // Half a turn, start angle for the left half plane
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // Saturation of radius over wheel radius, 1.0 in Q16
    localparam logic [16:0] SAT_ONE = 17'h1_0000;

    // Channel limits
    localparam logic [7:0] CHAN_MAX = 8'd255;

    // Control that travels with each pipeline stage
    typedef struct packed {
        logic valid;
        logic in_wheel;
    } t_hslw_ctl;

endpackage

@@ sv/hslw_cordic.sv @@
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
// Returns the scaled magnitude and the angle in turns modulo 2^32.
// Depends on hslw_pkg.
module hslw_cordic #(
    parameter int XY_W = 27
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  hslw_pkg::t_hslw_ctl     i_ctl,
    input  logic signed [XY_W-1:0]  i_x,
    input  logic signed [XY_W-1:0]  i_y,
    input  logic [31:0]             i_z,
    output hslw_pkg::t_hslw_ctl     o_ctl,
    output logic signed [XY_W-1:0]  o_x,
    output logic [31:0]             o_z
);
    import hslw_pkg::*;

    t_hslw_ctl               r_ctl [CORDIC_STEPS];
    logic signed [XY_W-1:0]  r_x   [CORDIC_STEPS];
    logic signed [XY_W-1:0]  r_y   [CORDIC_STEPS];
    logic [31:0]             r_z   [CORDIC_STEPS];

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
        t_hslw_ctl              c_in;
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        logic [31:0]            z_in;
        logic signed [XY_W-1:0] n_x;
        logic signed [XY_W-1:0] n_y;
        logic [31:0]            n_z;

        if (s == 0) begin : g_first
            assign c_in = i_ctl;
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
        end else begin : g_next
            assign c_in = r_ctl[s-1];
            assign x_in = r_x[s-1];
            assign y_in = r_y[s-1];
            assign z_in = r_z[s-1];
        end

        // rotate toward the x axis, direction from the sign of y
        always_comb begin
            if (!y_in[XY_W-1]) begin
                n_x = x_in + (y_in >>> s);
                n_y = y_in - (x_in >>> s);
                n_z = z_in + ATAN_TURNS[s];
            end else begin
                n_x = x_in - (y_in >>> s);
                n_y = y_in + (x_in >>> s);
                n_z = z_in - ATAN_TURNS[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s] <= '0;
            end else if (i_en) begin
                r_ctl[s] <= c_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s] <= n_x;
                r_y[s] <= n_y;
                r_z[s] <= n_z;
            end
        end
    end

    assign o_ctl = r_ctl[CORDIC_STEPS-1];
    assign o_x   = r_x[CORDIC_STEPS-1];
    assign o_z   = r_z[CORDIC_STEPS-1];

endmodule

@@ sv/hsl_color_wheel_pixel_top.sv @@
// HSL color wheel pixel generator: top level with geometry, CORDIC and color stages.
// Depends on hslw_pkg and hslw_cordic.
//
// One pixel coordinate is taken per clock and one color leaves per clock while
// the output is not stalled; the pipeline has an entry stage, 16 CORDIC
// micro-rotation stages and five stages for gain correction, radius division,
// chroma, hue weighting and channel clamp. The whole pipeline and the input
// stall only while the output is stalled with an untaken result in its register.
// The lightness slider is read live by the chroma and channel stages, so write
// it only while the pipeline is empty. Pixels outside the wheel come out white
// with inside_wheel low; the center pixel comes out grey at the set lightness.
module hsl_color_wheel_pixel_top #(
    parameter int WHEEL_DIAMETER = 256,
    parameter int ANGLE_BITS     = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    // pixel request
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_pixel_x,
    input  logic [7:0] i_pixel_y,
    // color result
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_inside_wheel
);
    import hslw_pkg::*;

    // geometry and widths
    localparam int R      = WHEEL_DIAMETER / 2;
    localparam int MAXC   = (R > 255) ? R : 255;
    localparam int D_W    = $clog2(MAXC + 1) + 1;
    localparam int SQ_W   = 2 * D_W;
    localparam int XY_W   = D_W + 18;
    localparam int RAD_W  = XY_W - 1;
    localparam int DIV_S  = RAD_W + $clog2(R);
    localparam int M_W    = RAD_W + 2;
    localparam int PW     = RAD_W + M_W;
    localparam int C_W    = 24;
    localparam int W_W    = ANGLE_BITS + 1;
    localparam int SUM_W  = 26;
    localparam logic [63:0] DIV_M_L = ((64'd1 << DIV_S) + 64'(R) - 64'd1) / 64'(R);
    localparam logic [M_W-1:0]        DIV_M = DIV_M_L[M_W-1:0];
    localparam logic signed [D_W-1:0] R_S   = D_W'(R);
    localparam logic signed [SQ_W-1:0] RR_S = SQ_W'(R * R);
    localparam logic [W_W-1:0]        W_ONE = W_W'(1) << ANGLE_BITS;

    // configuration register
    logic [7:0] r_slider;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slider <= 8'd175;
        end else if (i_cfg_wr_en) begin
            r_slider <= i_cfg_wr_data;
        end
    end

    // lightness and chroma scale from the slider
    logic [7:0]        lval;
    logic signed [9:0] ktwo;
    logic [7:0]        kval;

    always_comb begin
        lval = CHAN_MAX - r_slider;
        ktwo = $signed({1'b0, lval, 1'b0}) - 10'sd255;
        if (ktwo < 0) begin
            ktwo = -ktwo;
        end
        kval = CHAN_MAX - ktwo[7:0];
    end

    // pipeline advance
    logic r_out_valid;
    logic adv;

    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    // entry: offsets, inside test, CORDIC start values
    logic signed [D_W-1:0]  dx, dy;
    logic signed [SQ_W-1:0] dxx, dyy;
    logic signed [XY_W-1:0] xe, ye;
    t_hslw_ctl              n0_ctl;
    logic signed [XY_W-1:0] n0_x, n0_y;
    logic [31:0]            n0_z;

    always_comb begin
        dx  = $signed({{(D_W-8){1'b0}}, i_pixel_x}) - R_S;
        dy  = R_S - $signed({{(D_W-8){1'b0}}, i_pixel_y});
        dxx = SQ_W'(dx) * SQ_W'(dx);
        dyy = SQ_W'(dy) * SQ_W'(dy);
        n0_ctl.valid    = i_valid;
        n0_ctl.in_wheel = (dxx + dyy) < RR_S;
        xe = XY_W'(dx);
        ye = XY_W'(dy);
        if (dx[D_W-1]) begin
            n0_x = (-xe) <<< 16;
            n0_y = (-ye) <<< 16;
            n0_z = HALF_TURN;
        end else begin
            n0_x = xe <<< 16;
            n0_y = ye <<< 16;
            n0_z = '0;
        end
    end

    t_hslw_ctl              r0_ctl;
    logic signed [XY_W-1:0] r0_x, r0_y;
    logic [31:0]            r0_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
        end else if (adv) begin
            r0_ctl <= n0_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_x <= n0_x;
            r0_y <= n0_y;
            r0_z <= n0_z;
        end
    end

    // CORDIC pipeline
    t_hslw_ctl              c_ctl;
    logic signed [XY_W-1:0] c_x;
    logic [31:0]            c_z;

    hslw_cordic #(
        .XY_W (XY_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ctl   (r0_ctl),
        .i_x     (r0_x),
        .i_y     (r0_y),
        .i_z     (r0_z),
        .o_ctl   (c_ctl),
        .o_x     (c_x),
        .o_z     (c_z)
    );

    // stage 1: gain correction, hue sector and weight
    logic [RAD_W-1:0]          xc;
    logic [RAD_W+31:0]         gprod;
    logic [ANGLE_BITS-1:0]     ang;
    logic [ANGLE_BITS+2:0]     hue6;
    logic [2:0]                n1_sector;
    logic [ANGLE_BITS-1:0]     hfrac;
    logic [W_W-1:0]            n1_w;

    always_comb begin
        xc        = c_x[XY_W-1] ? '0 : c_x[RAD_W-1:0];
        gprod     = (RAD_W+32)'(xc) * (RAD_W+32)'(INV_GAIN_Q32);
        ang       = c_z[31 -: ANGLE_BITS];
        hue6      = (ANGLE_BITS+3)'(ang) * (ANGLE_BITS+3)'(6);
        n1_sector = hue6[ANGLE_BITS+2:ANGLE_BITS];
        hfrac     = hue6[ANGLE_BITS-1:0];
        n1_w      = n1_sector[0] ? (W_ONE - W_W'(hfrac)) : W_W'(hfrac);
    end

    t_hslw_ctl        r1_ctl;
    logic [RAD_W-1:0] r1_rad;
    logic [2:0]       r1_sector;
    logic [W_W-1:0]   r1_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (adv) begin
            r1_ctl <= c_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_rad    <= gprod[RAD_W+31:32];
            r1_sector <= n1_sector;
            r1_w      <= n1_w;
        end
    end

    // stage 2: radius over wheel radius by reciprocal multiply
    logic [PW-1:0] dprod;
    logic [PW-1:0] dquo;

    always_comb begin
        dprod = PW'(r1_rad) * PW'(DIV_M);
        dquo  = dprod >> DIV_S;
    end

    t_hslw_ctl        r2_ctl;
    logic [RAD_W-1:0] r2_q;
    logic [2:0]       r2_sector;
    logic [W_W-1:0]   r2_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (adv) begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_q      <= dquo[RAD_W-1:0];
            r2_sector <= r1_sector;
            r2_w      <= r1_w;
        end
    end

    // stage 3: saturation and chroma
    logic [16:0]  psat;
    logic [24:0]  cprod;

    always_comb begin
        psat  = (r2_q > RAD_W'(SAT_ONE)) ? SAT_ONE : r2_q[16:0];
        cprod = 25'(kval) * 25'(psat);
    end

    t_hslw_ctl      r3_ctl;
    logic [C_W-1:0] r3_c;
    logic [2:0]     r3_sector;
    logic [W_W-1:0] r3_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (adv) begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_c      <= cprod[C_W-1:0];
            r3_sector <= r2_sector;
            r3_w      <= r2_w;
        end
    end

    // stage 4: intermediate component
    logic [C_W+W_W-1:0] tprod;

    assign tprod = (C_W+W_W)'(r3_c) * (C_W+W_W)'(r3_w);

    t_hslw_ctl      r4_ctl;
    logic [C_W-1:0] r4_c;
    logic [C_W-1:0] r4_t;
    logic [2:0]     r4_sector;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (adv) begin
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_c      <= r3_c;
            r4_t      <= tprod[ANGLE_BITS +: C_W];
            r4_sector <= r3_sector;
        end
    end

    // stage 5: sector mapping, offset and clamp
    logic [C_W-1:0]          ch_r, ch_g, ch_b;
    logic signed [SUM_W-1:0] base;

    function automatic logic [7:0] to_chan(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-17:0] q;
        q = v[SUM_W-1:16];
        if (q < 0) begin
            return 8'd0;
        end else if (q > $signed((SUM_W-16)'(CHAN_MAX))) begin
            return CHAN_MAX;
        end
        return q[7:0];
    endfunction

    always_comb begin
        base = $signed(SUM_W'({lval, 16'h0000})) - $signed(SUM_W'(r4_c >> 1));
        unique case (r4_sector)
            3'd0:    begin ch_r = r4_c; ch_g = r4_t; ch_b = '0;   end
            3'd1:    begin ch_r = r4_t; ch_g = r4_c; ch_b = '0;   end
            3'd2:    begin ch_r = '0;   ch_g = r4_c; ch_b = r4_t; end
            3'd3:    begin ch_r = '0;   ch_g = r4_t; ch_b = r4_c; end
            3'd4:    begin ch_r = r4_t; ch_g = '0;   ch_b = r4_c; end
            default: begin ch_r = r4_c; ch_g = '0;   ch_b = r4_t; end
        endcase
    end

    logic [7:0] r_out_red, r_out_green, r_out_blue;
    logic       r_out_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r4_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r4_ctl.in_wheel) begin
                r_out_red   <= to_chan($signed(SUM_W'(ch_r)) + base);
                r_out_green <= to_chan($signed(SUM_W'(ch_g)) + base);
                r_out_blue  <= to_chan($signed(SUM_W'(ch_b)) + base);
            end else begin
                r_out_red   <= CHAN_MAX;
                r_out_green <= CHAN_MAX;
                r_out_blue  <= CHAN_MAX;
            end
            r_out_inside <= r4_ctl.in_wheel;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red          = r_out_red;
    assign o_green        = r_out_green;
    assign o_blue         = r_out_blue;
    assign o_inside_wheel = r_out_inside;

    // checks
    a_bg_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inside_wheel) |->
            (o_red == CHAN_MAX && o_green == CHAN_MAX && o_blue == CHAN_MAX))
        else $error("background pixel not white");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with output free");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
